// ===== rtl/core/c2u_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2u_pkg
// Shared types, constants and the CP-1252 upper-control table for the
// CP-1252 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package c2u_pkg;

	localparam logic [15:0] CP_TWO_BYTE_MIN   = 16'h0080;
	localparam logic [15:0] CP_THREE_BYTE_MIN = 16'h0800;
	localparam logic [7:0]  LEAD2             = 8'hC0;
	localparam logic [7:0]  LEAD3             = 8'hE0;
	localparam logic [7:0]  CONT              = 8'h80;
	localparam logic [7:0]  CTRL_LO           = 8'h80;
	localparam logic [7:0]  CTRL_HI           = 8'hA0;

	typedef logic [1:0] byte_idx_t;

	// One decoded character: its UTF-8 bytes in emit order and the index of
	// the final byte.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		byte_idx_t       last_idx;
		logic            term;
	} cmd_t;

	function automatic logic [15:0] high_map(input logic [4:0] idx);
		logic [15:0] cp;
		unique case (idx)
			5'd0:  cp = 16'h20AC;
			5'd1:  cp = 16'h0081;
			5'd2:  cp = 16'h201A;
			5'd3:  cp = 16'h0192;
			5'd4:  cp = 16'h201E;
			5'd5:  cp = 16'h2026;
			5'd6:  cp = 16'h2020;
			5'd7:  cp = 16'h2021;
			5'd8:  cp = 16'h02C6;
			5'd9:  cp = 16'h2030;
			5'd10: cp = 16'h0160;
			5'd11: cp = 16'h2039;
			5'd12: cp = 16'h0152;
			5'd13: cp = 16'h008D;
			5'd14: cp = 16'h017D;
			5'd15: cp = 16'h008F;
			5'd16: cp = 16'h0090;
			5'd17: cp = 16'h2018;
			5'd18: cp = 16'h2019;
			5'd19: cp = 16'h201C;
			5'd20: cp = 16'h201D;
			5'd21: cp = 16'h2022;
			5'd22: cp = 16'h2013;
			5'd23: cp = 16'h2014;
			5'd24: cp = 16'h02DC;
			5'd25: cp = 16'h2122;
			5'd26: cp = 16'h0161;
			5'd27: cp = 16'h203A;
			5'd28: cp = 16'h0153;
			5'd29: cp = 16'h009D;
			5'd30: cp = 16'h017E;
			default: cp = 16'h0178;
		endcase
		return cp;
	endfunction

endpackage

// ===== rtl/core/cp1252_to_utf8_transcoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp1252_to_utf8_transcoder
// Converts a stream of CP-1252 source words into UTF-8 words.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_ready    cp1252_byte, end_of_data
//   out      out_valid/out_ready  utf8_byte, last_of_char, string_end
//
// Each source word yields one, two or three output words, one per cycle from
// the output register while the queue holds words and out_ready does not
// stall it. The input side is classified in the cycle it is accepted and
// buffered in a QDEPTH-entry queue, whose head is then loaded into the output
// register. Reset empties the queue and the output register.
// ----------------------------------------------------------------------------
module cp1252_to_utf8_transcoder #(
	parameter int QDEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] cp1252_byte,
	input  logic       end_of_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] utf8_byte,
	output logic       last_of_char,
	output logic       string_end
);

	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_not_empty;
	c2u_pkg::cmd_t push_cmd;
	c2u_pkg::cmd_t head;

	c2u_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cp1252_byte (cp1252_byte),
		.end_of_data (end_of_data),
		.push        (push),
		.push_cmd    (push_cmd),
		.q_full      (q_full)
	);

	c2u_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	c2u_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.utf8_byte    (utf8_byte),
		.last_of_char (last_of_char),
		.string_end   (string_end)
	);

endmodule

// ===== rtl/core/c2u_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2u_front
// Classifies one source word: terminator, ASCII, table-mapped control range
// or Latin-1, and encodes the code point into up to three UTF-8 bytes.
// ----------------------------------------------------------------------------
module c2u_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        cp1252_byte,
	input  logic              end_of_data,
	output logic              push,
	output c2u_pkg::cmd_t     push_cmd,
	input  logic              q_full
);

	logic [15:0] cp;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		if (cp1252_byte >= c2u_pkg::CTRL_LO && cp1252_byte < c2u_pkg::CTRL_HI) begin
			cp = c2u_pkg::high_map(cp1252_byte[4:0]);
		end else begin
			cp = {8'h00, cp1252_byte};
		end
	end

	always_comb begin
		push_cmd = '0;
		if (end_of_data || cp1252_byte == 8'h00) begin
			push_cmd.term = 1'b1;
		end else if (cp < c2u_pkg::CP_TWO_BYTE_MIN) begin
			push_cmd.bytes[0] = cp[7:0];
		end else if (cp < c2u_pkg::CP_THREE_BYTE_MIN) begin
			push_cmd.bytes[0] = c2u_pkg::LEAD2 | {3'b000, cp[10:6]};
			push_cmd.bytes[1] = c2u_pkg::CONT | {2'b00, cp[5:0]};
			push_cmd.last_idx = 2'd1;
		end else begin
			push_cmd.bytes[0] = c2u_pkg::LEAD3 | {4'h0, cp[15:12]};
			push_cmd.bytes[1] = c2u_pkg::CONT | {2'b00, cp[11:6]};
			push_cmd.bytes[2] = c2u_pkg::CONT | {2'b00, cp[5:0]};
			push_cmd.last_idx = 2'd2;
		end
	end

endmodule

// ===== rtl/core/c2u_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2u_queue
// Short register queue of decoded characters between the front and back.
// ----------------------------------------------------------------------------
module c2u_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  c2u_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output c2u_pkg::cmd_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	c2u_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/c2u_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2u_back
// Emits the bytes of the queue head one per cycle into an output register,
// unless out_ready stalls it, and releases the entry with its final byte.
// ----------------------------------------------------------------------------
module c2u_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_not_empty,
	input  c2u_pkg::cmd_t     head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        utf8_byte,
	output logic              last_of_char,
	output logic              string_end
);

	c2u_pkg::byte_idx_t idx_q;
	logic               valid_q;
	logic [7:0]         byte_q;
	logic               last_q;
	logic               end_q;
	logic               load;
	logic               is_last;
	logic [7:0]         sel_byte;

	assign load    = !valid_q || out_ready;
	assign is_last = (idx_q == head.last_idx);
	assign pop     = load && q_not_empty && is_last;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.bytes[0];
			2'd1:    sel_byte = head.bytes[1];
			default: sel_byte = head.bytes[2];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= q_not_empty;
			if (q_not_empty) begin
				idx_q <= is_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_not_empty) begin
			byte_q <= sel_byte;
			last_q <= is_last;
			end_q  <= head.term;
		end
	end

	assign out_valid    = valid_q;
	assign utf8_byte    = byte_q;
	assign last_of_char = last_q;
	assign string_end   = end_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CP-1252 to UTF-8 transcoder. Source words are
// driven through the valid/ready input channel while the output channel is
// stalled at random. A scoreboard encodes each accepted source word into its
// UTF-8 words and compares them, in order, with the words the block emits.
// The run covers directed corner bytes, then random strings under three
// idling mixes.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_WORDS_PER_PHASE = 83;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       term;
	} utf8_word_t;

	class utf8_checker;
		utf8_word_t expected_words[$];
		int         mismatches;

		function new();
			mismatches = 0;
		endfunction

		function logic [15:0] code_point(input logic [7:0] b);
			logic [15:0] cp;
			cp = {8'h00, b};
			case (b)
				8'h80: cp = 16'h20AC;
				8'h82: cp = 16'h201A;
				8'h83: cp = 16'h0192;
				8'h84: cp = 16'h201E;
				8'h85: cp = 16'h2026;
				8'h86: cp = 16'h2020;
				8'h87: cp = 16'h2021;
				8'h88: cp = 16'h02C6;
				8'h89: cp = 16'h2030;
				8'h8A: cp = 16'h0160;
				8'h8B: cp = 16'h2039;
				8'h8C: cp = 16'h0152;
				8'h8E: cp = 16'h017D;
				8'h91: cp = 16'h2018;
				8'h92: cp = 16'h2019;
				8'h93: cp = 16'h201C;
				8'h94: cp = 16'h201D;
				8'h95: cp = 16'h2022;
				8'h96: cp = 16'h2013;
				8'h97: cp = 16'h2014;
				8'h98: cp = 16'h02DC;
				8'h99: cp = 16'h2122;
				8'h9A: cp = 16'h0161;
				8'h9B: cp = 16'h203A;
				8'h9C: cp = 16'h0153;
				8'h9E: cp = 16'h017E;
				8'h9F: cp = 16'h0178;
				default: cp = {8'h00, b};
			endcase
			return cp;
		endfunction

		function void push_word(input logic [7:0] data, input logic last, input logic term);
			utf8_word_t w;
			w.data = data;
			w.last = last;
			w.term = term;
			expected_words.insert(expected_words.size(), w);
		endfunction

		function void note_source(input logic [7:0] b, input logic eod);
			logic [15:0] cp;
			if (eod || b == 8'h00) begin
				push_word(8'h00, 1'b1, 1'b1);
				return;
			end
			cp = code_point(b);
			if (cp < c2u_pkg::CP_TWO_BYTE_MIN) begin
				push_word(cp[7:0], 1'b1, 1'b0);
			end else if (cp < c2u_pkg::CP_THREE_BYTE_MIN) begin
				push_word(c2u_pkg::LEAD2 | {3'b000, cp[10:6]}, 1'b0, 1'b0);
				push_word(c2u_pkg::CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0);
			end else begin
				push_word(c2u_pkg::LEAD3 | {4'h0, cp[15:12]}, 1'b0, 1'b0);
				push_word(c2u_pkg::CONT | {2'b00, cp[11:6]}, 1'b0, 1'b0);
				push_word(c2u_pkg::CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0);
			end
		endfunction

		function void check_word(input logic [7:0] data, input logic last, input logic term);
			utf8_word_t w;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected word: data %h last %b end %b", data, last, term);
				return;
			end
			w = expected_words.pop_front();
			if (w.data !== data || w.last !== last || w.term !== term) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Word mismatch: expected data %h last %b end %b, got data %h last %b end %b",
						w.data, w.last, w.term, data, last, term);
			end
		endfunction

		function int outstanding();
			return expected_words.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] cp1252_byte = 8'h00;
	logic       end_of_data = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] utf8_byte;
	logic       last_of_char;
	logic       string_end;

	int send_idle = 30;
	int recv_idle = 76;
	int cycles = 0;

	utf8_checker board = new();

	cp1252_to_utf8_transcoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cp1252_byte (cp1252_byte),
		.end_of_data (end_of_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.utf8_byte   (utf8_byte),
		.last_of_char(last_of_char),
		.string_end  (string_end)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_word(utf8_byte, last_of_char, string_end);
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_source(input logic [7:0] b, input logic eod);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		in_valid    <= 1'b1;
		cp1252_byte <= b;
		end_of_data <= eod;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_source(b, eod);
	endtask

	task automatic send_random_source();
		int         pick;
		logic [7:0] b;
		logic       eod;
		pick = $urandom_range(99);
		eod  = 1'b0;
		if (pick < 6) begin
			eod = 1'b1;
			b   = 8'($urandom_range(255));
		end else if (pick < 12) begin
			b = 8'h00;
		end else if (pick < 40) begin
			b = 8'($urandom_range(8'h9F, 8'h80));
		end else begin
			b = 8'($urandom_range(255, 1));
		end
		send_source(b, eod);
	endtask

	task automatic wait_until_drained();
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [7:0] corner_bytes[$];
		corner_bytes = '{8'h41, 8'h01, 8'h7F, 8'h00, 8'h80, 8'h81, 8'h8D, 8'h8F, 8'h90,
			8'h9D, 8'h83, 8'h8A, 8'h99, 8'h9F, 8'hA0, 8'hC3, 8'hFF, 8'h00};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_idle = 30;
		recv_idle = 76;
		foreach (corner_bytes[i])
			send_source(corner_bytes[i], 1'b0);
		send_source(8'hFF, 1'b1);
		send_source(8'h41, 1'b1);
		send_source(8'h00, 1'b1);
		send_source(8'h80, 1'b1);

		for (int i = 0; i < RANDOM_WORDS_PER_PHASE; i++) begin
			send_random_source();
			if (i == RANDOM_WORDS_PER_PHASE / 2) begin
				in_valid <= 1'b0;
				wait_until_drained();
			end
		end

		send_idle = 76;
		recv_idle = 30;
		for (int i = 0; i < RANDOM_WORDS_PER_PHASE; i++)
			send_random_source();

		send_idle = 0;
		recv_idle = 0;
		for (int i = 0; i < RANDOM_WORDS_PER_PHASE; i++)
			send_random_source();

		in_valid <= 1'b0;
		wait_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
